FILE: hw/rtl/button_debounce_press_classifier_assert.svh
// assertion macros for the checker file of the press classifier
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// property checked outside reset
`define BDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define BDPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bdpc_pkg.sv
// types and constants of the switch debounce and press classifier
// used by the top level and the port checker; no dependencies
package bdpc_pkg;

  localparam int NUM_SWITCHES_DEF = 4;
  localparam int LEVEL_W = 4;
  localparam int CIDX_W  = 2;
  localparam int EV_W    = 3;
  localparam int TMR_W   = 12;
  localparam int OUT_FIELDS = 4;

  localparam logic [TMR_W-1:0] TIMER_MAX      = '1;
  localparam logic [TMR_W-1:0] BOUNCE_MS_RST  = 12'd20;
  localparam logic [TMR_W-1:0] SHORT_MS_RST   = 12'd1000;
  localparam logic [TMR_W-1:0] LONG_MS_RST    = 12'd2000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_BOUNCE = 2'd0,
    REG_SHORT  = 2'd1,
    REG_LONG   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESSED   = 3'd1,
    ST_BOUNCE    = 3'd2,
    ST_CONFIRMED = 3'd3,
    ST_HOLD      = 3'd4,
    ST_HOLD_LONG = 3'd5,
    ST_REL_WAIT  = 3'd6
  } press_st_t;

  typedef enum logic [EV_W-1:0] {
    EV_IDLE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

endpackage

FILE: hw/rtl/button_debounce_press_classifier.sv
// Debounce and short/long press classifier for active-low push switches.
// Accepts one input beat every clock cycle while the result side is not stalled and
// returns one result beat for each: the beat is captured in an input register, then
// every switch's press machine, timer and event code are updated in one pass and
// the four event codes are loaded into the result register. The rate is set by
// that one-pass per-switch update; a stalled result holds the input stage,
// and a new beat enters whenever the input register is empty or moving on.
// in_tuser carries the operation (tick, poll, clear); in_tdata the switch levels
// and the clear index. Configuration writes apply from the next item on.
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] switch_levels, [5:4] clear_index, [7:6] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] event_sw0, [5:3] event_sw1,
                                  // [8:6] event_sw2, [11:9] event_sw3, [15:12] zero
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  // configuration registers
  logic [TMR_W-1:0] bounce_ms_r, short_ms_r, long_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_ms_r <= BOUNCE_MS_RST;
      short_ms_r  <= SHORT_MS_RST;
      long_ms_r   <= LONG_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOUNCE: bounce_ms_r <= cfg_wdata;
        REG_SHORT:  short_ms_r  <= cfg_wdata;
        REG_LONG:   long_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  logic               s1_valid_r;
  logic [1:0]         s1_op_r;
  logic [LEVEL_W-1:0] s1_lvl_r;
  logic [CIDX_W-1:0]  s1_ci_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;
  logic               adv;
  logic               fire2;
  logic               in_fire;

  assign adv       = !out_valid_r || out_tready;
  assign fire2     = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tuser;
      s1_lvl_r <= in_tdata[3:0];
      s1_ci_r  <= in_tdata[5:4];
    end
  end

  // per-switch state
  press_st_t        fsm_r   [NUM_SWITCHES];
  press_st_t        fsm_nxt [NUM_SWITCHES];
  event_t           ev_r    [NUM_SWITCHES];
  event_t           ev_nxt  [NUM_SWITCHES];
  logic [TMR_W-1:0] tmr_r   [NUM_SWITCHES];
  logic [TMR_W-1:0] tmr_nxt [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] down;

  // switches beyond the level field read as released
  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (i < LEVEL_W) down[i] = ~s1_lvl_r[2'(i)];
      else             down[i] = 1'b0;
    end
  end

  // next state of the press machines
  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      fsm_nxt[i] = fsm_r[i];
      if (s1_op_r == OP_POLL) begin
        case (fsm_r[i])
          ST_IDLE:      if (down[i]) fsm_nxt[i] = ST_PRESSED;
          ST_PRESSED:   fsm_nxt[i] = ST_BOUNCE;
          ST_BOUNCE: begin
            if (tmr_r[i] >= bounce_ms_r) fsm_nxt[i] = down[i] ? ST_CONFIRMED : ST_IDLE;
            else if (!down[i])           fsm_nxt[i] = ST_IDLE;
          end
          ST_CONFIRMED: fsm_nxt[i] = ST_HOLD;
          ST_HOLD: begin
            if (!down[i])                fsm_nxt[i] = ST_REL_WAIT;
            else if (tmr_r[i] > long_ms_r) fsm_nxt[i] = ST_HOLD_LONG;
          end
          ST_HOLD_LONG: if (!down[i]) fsm_nxt[i] = ST_REL_WAIT;
          ST_REL_WAIT:  if (tmr_r[i] >= bounce_ms_r) fsm_nxt[i] = ST_IDLE;
          default:      fsm_nxt[i] = ST_IDLE;
        endcase
      end
    end
  end

  // timers and event codes
  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      ev_nxt[i]  = ev_r[i];
      tmr_nxt[i] = tmr_r[i];
      case (s1_op_r)
        OP_TICK: begin
          // saturates at long_ms + 1, and never wraps
          if (tmr_r[i] <= long_ms_r && tmr_r[i] != TIMER_MAX) tmr_nxt[i] = tmr_r[i] + 1'b1;
        end
        OP_POLL: begin
          case (fsm_r[i])
            ST_PRESSED: tmr_nxt[i] = '0;
            ST_CONFIRMED: begin
              tmr_nxt[i] = '0;
              ev_nxt[i]  = EV_PRESSED;
            end
            ST_HOLD: begin
              // release wins over the long check
              if (!down[i]) begin
                ev_nxt[i]  = (tmr_r[i] < short_ms_r) ? EV_SHORT : EV_LONG;
                tmr_nxt[i] = '0;
              end else if (tmr_r[i] > long_ms_r) begin
                ev_nxt[i] = EV_LONG;
              end
            end
            ST_HOLD_LONG: if (!down[i]) tmr_nxt[i] = '0;
            ST_REL_WAIT:  if (tmr_r[i] >= bounce_ms_r) ev_nxt[i] = EV_RELEASED;
            default: ;
          endcase
        end
        OP_CLEAR: if (int'(s1_ci_r) == i) ev_nxt[i] = EV_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        fsm_r[i] <= ST_IDLE;
        ev_r[i]  <= EV_IDLE;
        tmr_r[i] <= '0;
      end
    end else if (fire2) begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        fsm_r[i] <= fsm_nxt[i];
        ev_r[i]  <= ev_nxt[i];
        tmr_r[i] <= tmr_nxt[i];
      end
    end
  end

  // result packing; missing switches read idle
  logic [OUT_FIELDS-1:0][EV_W-1:0] pack_nxt;

  for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_pack
    if (k < NUM_SWITCHES) begin : g_sw
      assign pack_nxt[k] = ev_nxt[k];
    end else begin : g_none
      assign pack_nxt[k] = EV_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) out_data_r <= {4'b0, pack_nxt};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/bdpc_checker.sv
// port-level checks for the press classifier, bound to its top level
// depends on bdpc_pkg and the assertion macro header
`include "button_debounce_press_classifier_assert.svh"

module bdpc_checker
  import bdpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result beat holds
  `BDPC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // an empty result register never blocks the input side
  `BDPC_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty result register")

  // event codes stay in range and padding stays zero
  `BDPC_ASSERT(a_codes_valid, out_tvalid |-> out_tdata[15:12] == 4'b0 && out_tdata[2:0] <= EV_RELEASED && out_tdata[5:3] <= EV_RELEASED && out_tdata[8:6] <= EV_RELEASED && out_tdata[11:9] <= EV_RELEASED, "bad event code in result beat")

  // reset empties the result side
  `BDPC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result beat present after reset")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/button_debounce_press_classifier_tb.sv
// self-checking testbench for the switch debounce and press classifier
// drives tick, poll and clear beats under random idling and checks all four event codes
// depends on bdpc_pkg and the button_debounce_press_classifier rtl
module button_debounce_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 80;

  class press_event_scoreboard;
    logic [11:0] bounce_len, short_len, long_len;
    press_st_t   sw_state [4];
    event_t      sw_event [4];
    logic [11:0] sw_timer [4];
    logic [15:0] expected_events [$];
    int          errors;

    function new();
      bounce_len = BOUNCE_MS_RST;
      short_len  = SHORT_MS_RST;
      long_len   = LONG_MS_RST;
      errors     = 0;
      for (int i = 0; i < 4; i++) begin
        sw_state[i] = ST_IDLE;
        sw_event[i] = EV_IDLE;
        sw_timer[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [11:0] val);
      case (idx)
        REG_BOUNCE: bounce_len = val;
        REG_SHORT:  short_len  = val;
        REG_LONG:   long_len   = val;
        default: ;
      endcase
    endfunction

    function void step_switch(int i, bit down);
      case (sw_state[i])
        ST_IDLE: if (down) sw_state[i] = ST_PRESSED;
        ST_PRESSED: begin
          sw_timer[i] = '0;
          sw_state[i] = ST_BOUNCE;
        end
        ST_BOUNCE: begin
          if (sw_timer[i] >= bounce_len) sw_state[i] = down ? ST_CONFIRMED : ST_IDLE;
          else if (!down) sw_state[i] = ST_IDLE;
        end
        ST_CONFIRMED: begin
          sw_timer[i] = '0;
          sw_state[i] = ST_HOLD;
          sw_event[i] = EV_PRESSED;
        end
        ST_HOLD: begin
          // release takes priority over the long check
          if (!down) begin
            sw_event[i] = (sw_timer[i] < short_len) ? EV_SHORT : EV_LONG;
            sw_timer[i] = '0;
            sw_state[i] = ST_REL_WAIT;
          end else if (sw_timer[i] > long_len) begin
            sw_event[i] = EV_LONG;
            sw_state[i] = ST_HOLD_LONG;
          end
        end
        ST_HOLD_LONG: begin
          if (!down) begin
            sw_timer[i] = '0;
            sw_state[i] = ST_REL_WAIT;
          end
        end
        ST_REL_WAIT: begin
          if (sw_timer[i] >= bounce_len) begin
            sw_event[i] = EV_RELEASED;
            sw_state[i] = ST_IDLE;
          end
        end
        default: sw_state[i] = ST_IDLE;
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [3:0] levels, logic [1:0] idx);
      if (op == OP_TICK) begin
        // timer stops at long_len+1 and never wraps past all ones
        for (int i = 0; i < 4; i++)
          if (sw_timer[i] <= long_len && sw_timer[i] != TIMER_MAX)
            sw_timer[i] = sw_timer[i] + 12'd1;
      end else if (op == OP_POLL) begin
        for (int i = 0; i < 4; i++) step_switch(i, !levels[i]);
      end else if (op == OP_CLEAR) begin
        sw_event[idx] = EV_IDLE;
      end
      expected_events.push_back({4'h0, sw_event[3], sw_event[2], sw_event[1], sw_event[0]});
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [15:0] got);
      logic [15:0] want;
      if (expected_events.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_events.pop_front();
      for (int i = 0; i < 4; i++)
        if (got[3*i +: 3] !== want[3*i +: 3])
          report($sformatf("event_sw%0d got %0d want %0d", i, got[3*i +: 3], want[3*i +: 3]));
      if (got[15:12] !== 4'h0) report($sformatf("pad bits got %h", got[15:12]));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [3:0] switch_levels, [5:4] clear_index, [7:6] zero
  logic [1:0]  in_tuser = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [2:0] sw0, [5:3] sw1, [8:6] sw2, [11:9] sw3, [15:12] zero
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  press_event_scoreboard sb = new();
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   long_hold_req = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  logic [3:0] held_levels = 4'hF;

  button_debounce_press_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [3:0] levels,
                           input logic [1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, idx, levels};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, levels, idx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all three registers back to back, block must be idle
  task automatic set_config(input logic [11:0] bounce, input logic [11:0] short_v,
                            input logic [11:0] long_v);
    logic [11:0] vals [3];
    vals = '{bounce, short_v, long_v};
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
      sb.set_reg(reg_idx_t'(k), vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_small_config();
    set_config(12'($urandom_range(4)), 12'($urandom_range(12, 2)),
               12'($urandom_range(25, 5)));
  endtask

  // mostly steady switch patterns so presses run to completion, some noise
  task automatic run_random(input int n_items);
    int done, pick, burst, span;
    done = 0;
    span = (sb.long_len < 36) ? int'(sb.long_len) + 4 : 40;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        burst = $urandom_range(span, 1);
        repeat (burst) send_item(OP_TICK, 4'($urandom), 2'($urandom));
        done += burst;
      end else begin
        if (pick < 75) begin
          if ($urandom_range(2) == 0) held_levels ^= 4'b0001 << $urandom_range(3);
          send_item(OP_POLL, held_levels, 2'($urandom));
        end else if (pick < 85) begin
          send_item(OP_CLEAR, 4'($urandom), 2'($urandom));
        end else if (pick < 95) begin
          send_item(OP_POLL, 4'($urandom), 2'($urandom));
        end else begin
          send_item(OP_RSVD, 4'($urandom), 2'($urandom));
        end
        done++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 83;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings first, a reserved and a clear beat, then two switches pressed into bounce wait
    send_item(OP_RSVD, 4'hF, 2'd3);
    send_item(OP_CLEAR, 4'h0, 2'd3);
    send_item(OP_POLL, 4'h0, 2'd0);
    send_item(OP_POLL, 4'hA, 2'd1);
    send_item(OP_POLL, 4'hA, 2'd2);
    drain();
    // settings change while two switches sit in bounce wait
    set_config(12'd1, 12'd2, 12'd3);
    send_item(OP_TICK, 4'h5, 2'd1);
    send_item(OP_POLL, 4'h4, 2'd0);
    send_item(OP_POLL, 4'h4, 2'd0);
    send_item(OP_TICK, 4'h0, 2'd0);
    send_item(OP_POLL, 4'hF, 2'd0);
    send_item(OP_TICK, 4'hF, 2'd3);
    send_item(OP_POLL, 4'hF, 2'd0);
    send_item(OP_CLEAR, 4'hF, 2'd0);
    send_item(OP_POLL, 4'hE, 2'd0);
    send_item(OP_POLL, 4'hE, 2'd0);
    send_item(OP_TICK, 4'hE, 2'd0);
    send_item(OP_POLL, 4'hE, 2'd0);
    send_item(OP_POLL, 4'hE, 2'd0);
    repeat (5) send_item(OP_TICK, 4'hE, 2'd2);
    send_item(OP_POLL, 4'hE, 2'd0);
    send_item(OP_POLL, 4'hF, 2'd0);
    send_item(OP_TICK, 4'hF, 2'd0);
    send_item(OP_POLL, 4'hF, 2'd0);
    drain();

    set_config(12'd0, 12'd0, 12'd0);
    run_random(150);
    drain();
    set_small_config();
    run_random(320);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 32;
    set_config(12'd4000, 12'd4000, 12'd4000);
    run_random(100);
    drain();
    set_small_config();
    long_hold_req = 1'b1;
    run_random(320);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long at all ones: no early long report, the release still reports long
    set_config(12'd0, 12'd2, 12'hFFF);
    repeat (4) send_item(OP_POLL, 4'h0, 2'd0);
    repeat (40) send_item(OP_TICK, 4'h0, 2'd1);
    send_item(OP_POLL, 4'h0, 2'd0);
    send_item(OP_POLL, 4'hF, 2'd0);
    send_item(OP_TICK, 4'hF, 2'd0);
    send_item(OP_POLL, 4'hF, 2'd0);
    drain();
    set_small_config();
    long_hold_req = 1'b1;
    run_random(180);

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
